// ===== hw/rtl/hcbd_pkg.sv =====
// Shared types, codes and helpers for the chunked body decoder.
// No dependencies; used by every module in hw/rtl.
package hcbd_pkg;

   localparam int LEN_BITS_DEF  = 31;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_X_LO = 8'h78;
   localparam logic [7:0] CH_X_UP = 8'h58;

   typedef enum logic [6:0] {
      PH_SIZE_FIRST = 7'b0000001,
      PH_SIZE_MORE  = 7'b0000010,
      PH_SIZE_LF    = 7'b0000100,
      PH_DATA       = 7'b0001000,
      PH_DATA_CR    = 7'b0010000,
      PH_DATA_LF    = 7'b0100000,
      PH_STOPPED    = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY       = 3'd0,
      ST_DONE       = 3'd1,
      ST_BAD_CHAR   = 3'd2,
      ST_NO_SIZE_LF = 3'd3,
      ST_OVERFLOW   = 3'd4,
      ST_NO_DATA_CR = 3'd5,
      ST_NO_DATA_LF = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      PX_NONE        = 2'd0,
      PX_LONE_ZERO   = 2'd1,
      PX_DIGITS      = 2'd2,
      PX_AWAIT_DIGIT = 2'd3
   } prefix_type;

   localparam logic CSR_IDX_PASS_PAYLOAD = 1'b0;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      status_type status;
   } result_type;

   // {is_hex, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hcbd_csr.sv =====
// Configuration register block (pass_payload) behind an APB-style port.
// Depends on hcbd_pkg.
module hcbd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [hcbd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [hcbd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [hcbd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output logic                                 pass_payload
);

   logic pass_payload_ff;
   logic pass_payload_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      pass_payload_in = pass_payload_ff;
      if (wr_en && (paddr[2] == hcbd_pkg::CSR_IDX_PASS_PAYLOAD)) begin
         pass_payload_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_payload_ff <= 1'b1;
      end else begin
         pass_payload_ff <= pass_payload_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == hcbd_pkg::CSR_IDX_PASS_PAYLOAD) begin
         prdata[0] = pass_payload_ff;
      end
   end

   assign pass_payload = pass_payload_ff;

endmodule

// ===== hw/rtl/hcbd_fsm.sv =====
// Framing state and per-byte decode logic; state commits on each step.
// Depends on hcbd_pkg.
module hcbd_fsm #(
   parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             body_byte,
   input  logic                   pass_payload,
   output hcbd_pkg::result_type   result
);

   hcbd_pkg::phase_type  phase_ff,  phase_in;
   hcbd_pkg::prefix_type prefix_ff, prefix_in;
   hcbd_pkg::status_type status_ff, status_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;
   logic [LEN_BITS-1:0]  cnt_ff, cnt_in;
   logic [LEN_BITS-1:0]  cnt_inc;
   logic [4:0]           hex;
   logic                 is_hex;
   logic [3:0]           hv;
   logic                 pv;
   logic [7:0]           pb;

   assign hex     = hcbd_pkg::hex_value(body_byte);
   assign is_hex  = hex[4];
   assign hv      = hex[3:0];
   assign cnt_inc = cnt_ff + LEN_BITS'(1);

   always_comb begin
      phase_in  = phase_ff;
      prefix_in = prefix_ff;
      status_in = status_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      pv        = 1'b0;
      pb        = 8'd0;
      case (phase_ff)
         hcbd_pkg::PH_SIZE_FIRST: begin
            if (!is_hex) begin
               status_in = hcbd_pkg::ST_BAD_CHAR;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end else begin
               len_in    = LEN_BITS'(hv);
               prefix_in = (hv == 4'd0) ? hcbd_pkg::PX_LONE_ZERO : hcbd_pkg::PX_DIGITS;
               phase_in  = hcbd_pkg::PH_SIZE_MORE;
            end
         end
         hcbd_pkg::PH_SIZE_MORE: begin
            if (is_hex) begin
               prefix_in = hcbd_pkg::PX_DIGITS;
               if (len_ff[LEN_BITS-1 -: 4] != 4'd0) begin
                  status_in = hcbd_pkg::ST_OVERFLOW;
                  phase_in  = hcbd_pkg::PH_STOPPED;
               end else begin
                  len_in = {len_ff[LEN_BITS-5:0], hv};
               end
            end else if (body_byte == hcbd_pkg::CH_X_LO || body_byte == hcbd_pkg::CH_X_UP) begin
               if (prefix_ff == hcbd_pkg::PX_LONE_ZERO) begin
                  prefix_in = hcbd_pkg::PX_AWAIT_DIGIT;
                  len_in    = '0;
               end else begin
                  status_in = hcbd_pkg::ST_BAD_CHAR;
                  phase_in  = hcbd_pkg::PH_STOPPED;
               end
            end else if (body_byte == hcbd_pkg::CH_CR) begin
               if (prefix_ff == hcbd_pkg::PX_AWAIT_DIGIT) begin
                  status_in = hcbd_pkg::ST_BAD_CHAR;
                  phase_in  = hcbd_pkg::PH_STOPPED;
               end else begin
                  phase_in = hcbd_pkg::PH_SIZE_LF;
               end
            end else begin
               status_in = hcbd_pkg::ST_BAD_CHAR;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end
         end
         hcbd_pkg::PH_SIZE_LF: begin
            if (body_byte == hcbd_pkg::CH_LF) begin
               cnt_in   = '0;
               phase_in = (len_ff == '0) ? hcbd_pkg::PH_DATA_CR : hcbd_pkg::PH_DATA;
            end else begin
               status_in = hcbd_pkg::ST_NO_SIZE_LF;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (pass_payload) begin
               pv = 1'b1;
               pb = body_byte;
            end
            cnt_in = cnt_inc;
            if (cnt_inc >= len_ff) begin
               phase_in = hcbd_pkg::PH_DATA_CR;
            end
         end
         hcbd_pkg::PH_DATA_CR: begin
            if (body_byte == hcbd_pkg::CH_CR) begin
               phase_in = hcbd_pkg::PH_DATA_LF;
            end else begin
               status_in = hcbd_pkg::ST_NO_DATA_CR;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end
         end
         hcbd_pkg::PH_DATA_LF: begin
            if (body_byte != hcbd_pkg::CH_LF) begin
               status_in = hcbd_pkg::ST_NO_DATA_LF;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end else if (len_ff == '0) begin
               status_in = hcbd_pkg::ST_DONE;
               phase_in  = hcbd_pkg::PH_STOPPED;
            end else begin
               phase_in  = hcbd_pkg::PH_SIZE_FIRST;
               len_in    = '0;
               cnt_in    = '0;
               prefix_in = hcbd_pkg::PX_NONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= hcbd_pkg::PH_SIZE_FIRST;
         prefix_ff <= hcbd_pkg::PX_NONE;
         status_ff <= hcbd_pkg::ST_BUSY;
         len_ff    <= '0;
         cnt_ff    <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         prefix_ff <= prefix_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
      end
   end

   assign result.payload_valid = pv;
   assign result.payload_byte  = pb;
   assign result.status        = status_in;

endmodule

// ===== hw/rtl/http_chunked_body_decoder_top.sv =====
// Top level of the HTTP chunked body decoder: input register, decode, result register.
// Depends on hcbd_pkg, hcbd_csr, hcbd_fsm.
//
//   channel  | direction | handshake             | payload
//   req      | in        | req_valid/req_ready   | req_body_byte[7:0]
//   rsp      | out       | rsp_valid/rsp_ready   | rsp_payload_valid, rsp_payload_byte, rsp_status
//   csr      | in/out    | psel/penable/pready   | paddr[2:0], pwdata, prdata
//
// One beat per cycle while rsp is not stalled; each beat passes the input and result registers.
// The framing state updates as a byte moves from the input register to the result register.
// Synchronous active-high reset; the block accepts beats as soon as reset is low.
// A stalled rsp holds its result; the input register still takes one more beat.
module http_chunked_body_decoder_top #(
   parameter int LEN_BITS = hcbd_pkg::LEN_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_body_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_payload_valid,
   output logic [7:0]                           rsp_payload_byte,
   output logic [2:0]                           rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [hcbd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [hcbd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [hcbd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   logic                 pass_payload;
   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   hcbd_pkg::result_type out_result_ff;
   hcbd_pkg::result_type step_result;
   logic                 advance;
   logic                 req_fire;

   hcbd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .pass_payload (pass_payload)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !reset && (!in_valid_ff || advance);
   assign req_fire  = req_valid && req_ready;

   hcbd_fsm #(
      .LEN_BITS (LEN_BITS)
   ) u_fsm (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .body_byte    (in_byte_ff),
      .pass_payload (pass_payload),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_body_byte;
      end
      if (advance) begin
         out_result_ff <= step_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_result_ff.payload_valid;
   assign rsp_payload_byte  = out_result_ff.payload_byte;
   assign rsp_status        = out_result_ff.status;

endmodule

// ===== hw/rtl/hcbd_checker.sv =====
// Port-level checks for the chunked body decoder top, attached by bind.
// Depends on hcbd_pkg and http_chunked_body_decoder_top.
module hcbd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_payload_valid,
   input logic [7:0] rsp_payload_byte,
   input logic [2:0] rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_valid)
         && $stable(rsp_payload_byte) && $stable(rsp_status))
      else $error("rsp beat changed while stalled");

   a_no_data_after_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != hcbd_pkg::ST_BUSY) |-> !rsp_payload_valid)
      else $error("data beat with done or error status");

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |-> rsp_payload_byte == 8'd0)
      else $error("payload byte not zero on non-data beat");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_status        (rsp_status)
);

// ===== test/http_chunked_body_decoder_top_test.sv =====
// Self-checking testbench for http_chunked_body_decoder_top: streams chunked bodies,
// predicts each result beat in-line and compares it with the rsp channel.
// Depends on hcbd_pkg and the RTL under hw/rtl.
`timescale 1ns / 1ps

module http_chunked_body_decoder_top_test;

   localparam int LEN = hcbd_pkg::LEN_BITS_DEF;
   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_PRINTED = 50;
   localparam logic [hcbd_pkg::CSR_ADDR_BITS-1:0] ADDR_PASS_PAYLOAD =
      {hcbd_pkg::CSR_IDX_PASS_PAYLOAD, 2'b00};

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [7:0]                         req_body_byte = 8'h00;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic                               rsp_payload_valid;
   logic [7:0]                         rsp_payload_byte;
   logic [2:0]                         rsp_status;
   logic                               psel = 1'b0;
   logic                               penable = 1'b0;
   logic                               pwrite = 1'b0;
   logic [hcbd_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [hcbd_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [hcbd_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                               pready;

   http_chunked_body_decoder_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_body_byte(req_body_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_payload_valid(rsp_payload_valid), .rsp_payload_byte(rsp_payload_byte),
      .rsp_status(rsp_status),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // decoder state mirror
   logic                  pass_enabled = 1'b1;
   hcbd_pkg::phase_type   dec_phase = hcbd_pkg::PH_SIZE_FIRST;
   logic [LEN-1:0]        dec_len = '0;
   logic [LEN-1:0]        dec_count = '0;
   hcbd_pkg::prefix_type  dec_prefix = hcbd_pkg::PX_NONE;
   hcbd_pkg::status_type  dec_status = hcbd_pkg::ST_BUSY;

   hcbd_pkg::result_type expected_results[$];
   int error_count = 0;
   int bytes_sent = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_off_cycles = 0;
   int quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTED) $display("mismatch: %s", what);
      error_count++;
   endtask

   function automatic int hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) return 8'h30 + 8'(d);
      if ($urandom_range(1)) return 8'h61 + 8'(d) - 8'd10;
      return 8'h41 + 8'(d) - 8'd10;
   endfunction

   function automatic logic [7:0] random_except(input logic [7:0] avoid);
      logic [7:0] b;
      do b = 8'($urandom_range(255)); while (b == avoid);
      return b;
   endfunction

   function automatic void halt(input hcbd_pkg::status_type code);
      dec_status = code;
      dec_phase = hcbd_pkg::PH_STOPPED;
   endfunction

   function automatic hcbd_pkg::result_type decode_byte(input logic [7:0] c);
      hcbd_pkg::result_type r;
      int v;
      logic [3:0] val;
      r.payload_valid = 1'b0;
      r.payload_byte = 8'h00;
      v = hex_digit(c);
      val = v[3:0];
      case (dec_phase)
         hcbd_pkg::PH_SIZE_FIRST: begin
            if (v < 0) begin
               halt(hcbd_pkg::ST_BAD_CHAR);
            end else begin
               dec_len = LEN'(val);
               dec_prefix = (val == 4'd0) ? hcbd_pkg::PX_LONE_ZERO : hcbd_pkg::PX_DIGITS;
               dec_phase = hcbd_pkg::PH_SIZE_MORE;
            end
         end
         hcbd_pkg::PH_SIZE_MORE: begin
            if (v >= 0) begin
               if (dec_len[LEN-1:LEN-4] != '0) halt(hcbd_pkg::ST_OVERFLOW);
               else dec_len = {dec_len[LEN-5:0], val};
               dec_prefix = hcbd_pkg::PX_DIGITS;
            end else if (c == hcbd_pkg::CH_X_LO || c == hcbd_pkg::CH_X_UP) begin
               if (dec_prefix == hcbd_pkg::PX_LONE_ZERO) begin
                  dec_prefix = hcbd_pkg::PX_AWAIT_DIGIT;
                  dec_len = '0;
               end else begin
                  halt(hcbd_pkg::ST_BAD_CHAR);
               end
            end else if (c == hcbd_pkg::CH_CR) begin
               if (dec_prefix == hcbd_pkg::PX_AWAIT_DIGIT) halt(hcbd_pkg::ST_BAD_CHAR);
               else dec_phase = hcbd_pkg::PH_SIZE_LF;
            end else begin
               halt(hcbd_pkg::ST_BAD_CHAR);
            end
         end
         hcbd_pkg::PH_SIZE_LF: begin
            if (c == hcbd_pkg::CH_LF) begin
               dec_count = '0;
               dec_phase = (dec_len == '0) ? hcbd_pkg::PH_DATA_CR : hcbd_pkg::PH_DATA;
            end else begin
               halt(hcbd_pkg::ST_NO_SIZE_LF);
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (pass_enabled) begin
               r.payload_valid = 1'b1;
               r.payload_byte = c;
            end
            dec_count = dec_count + LEN'(1);
            if (dec_count >= dec_len) dec_phase = hcbd_pkg::PH_DATA_CR;
         end
         hcbd_pkg::PH_DATA_CR: begin
            if (c == hcbd_pkg::CH_CR) dec_phase = hcbd_pkg::PH_DATA_LF;
            else halt(hcbd_pkg::ST_NO_DATA_CR);
         end
         hcbd_pkg::PH_DATA_LF: begin
            if (c != hcbd_pkg::CH_LF) begin
               halt(hcbd_pkg::ST_NO_DATA_LF);
            end else if (dec_len == '0) begin
               halt(hcbd_pkg::ST_DONE);
            end else begin
               dec_phase = hcbd_pkg::PH_SIZE_FIRST;
               dec_len = '0;
               dec_count = '0;
               dec_prefix = hcbd_pkg::PX_NONE;
            end
         end
         default: ;
      endcase
      r.status = dec_status;
      return r;
   endfunction

   // result side: checking, ready pacing, watchdog
   always @(posedge clock) begin
      hcbd_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("unexpected rsp beat status=%0d", rsp_status));
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload_valid !== want.payload_valid)
                  report_mismatch($sformatf("payload_valid got %b want %b",
                                            rsp_payload_valid, want.payload_valid));
               if (rsp_payload_byte !== want.payload_byte)
                  report_mismatch($sformatf("payload_byte got %h want %h",
                                            rsp_payload_byte, want.payload_byte));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_body_byte <= b;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(decode_byte(b));
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_byte(s[i]);
   endtask

   task automatic send_crlf();
      send_byte(hcbd_pkg::CH_CR);
      send_byte(hcbd_pkg::CH_LF);
   endtask

   task automatic send_data(input int count);
      repeat (count) send_byte(8'($urandom_range(255)));
   endtask

   // size line with random prefix, leading zeros and letter case
   task automatic send_size_line(input int size);
      int kind;
      int n;
      logic [3:0] digits[$];
      kind = $urandom_range(3);
      if (kind >= 2) begin
         send_byte("0");
         send_byte(kind == 2 ? hcbd_pkg::CH_X_LO : hcbd_pkg::CH_X_UP);
      end
      repeat ($urandom_range(2)) send_byte("0");
      n = size;
      do begin
         digits.push_front(4'(n & 15));
         n = n >> 4;
      end while (n != 0);
      foreach (digits[i]) send_byte(hex_char(digits[i]));
      send_crlf();
   endtask

   task automatic send_chunk(input int size);
      send_size_line(size);
      send_data(size);
      send_crlf();
   endtask

   function automatic int random_size();
      int r;
      r = $urandom_range(99);
      if (r < 70) return $urandom_range(1, 16);
      if (r < 95) return $urandom_range(17, 64);
      return $urandom_range(65, 300);
   endfunction

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_PASS_PAYLOAD;
      pwdata <= hcbd_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pass_enabled = value;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read_check(input logic want);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_PASS_PAYLOAD;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[0] !== want)
         report_mismatch($sformatf("pass_payload read %b want %b", prdata[0], want));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_csr_access();
      csr_read_check(1'b1);
      csr_write(1'b0);
      csr_read_check(1'b0);
      csr_write(1'b1);
      csr_read_check(1'b1);
   endtask

   task automatic test_directed_framing();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_text("1");
      send_crlf();
      send_byte(8'h00);
      send_crlf();
      send_text("0X2");
      send_crlf();
      send_byte(8'hFF);
      send_byte(hcbd_pkg::CH_CR);
      send_crlf();
      send_text("0x0001");
      send_crlf();
      send_byte(hcbd_pkg::CH_LF);
      send_crlf();
   endtask

   task automatic test_random_chunks(input int idle_pct, input int stall_pct,
                                     input logic pass, input int count);
      int target;
      wait_results_drained();
      csr_write(pass);
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = bytes_sent + count;
      while (bytes_sent < target) send_chunk(random_size());
   endtask

   // rsp held off while req keeps offering: the block fills and stalls req
   task automatic test_backpressure();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_off_cycles = 120;
      send_chunk(48);
   endtask

   // sender pauses mid-chunk until every result is back
   task automatic test_drain_pause();
      req_idle_pct = 30;
      rsp_stall_pct = 30;
      send_size_line(20);
      send_data(10);
      wait_results_drained();
      send_data(10);
      send_crlf();
   endtask

   // ends the body once, either cleanly or with one framing fault
   task automatic test_termination();
      hcbd_pkg::status_type target;
      logic [7:0] b;
      wait_results_drained();
      csr_write(1'($urandom_range(1)));
      req_idle_pct = 30;
      rsp_stall_pct = 30;
      target = hcbd_pkg::status_type'($urandom_range(hcbd_pkg::ST_DONE,
                                                     hcbd_pkg::ST_NO_DATA_LF));
      case (target)
         hcbd_pkg::ST_DONE: begin
            case ($urandom_range(2))
               0: send_text("0");
               1: send_text("0x0");
               default: send_text("000");
            endcase
            send_crlf();
            send_crlf();
         end
         hcbd_pkg::ST_BAD_CHAR: begin
            case ($urandom_range(3))
               0: begin
                  do b = 8'($urandom_range(255)); while (hex_digit(b) >= 0);
                  send_byte(b);
               end
               1: send_text("5;ext");
               2: send_text("1x");
               default: begin
                  send_text("0x");
                  send_byte(hcbd_pkg::CH_CR);
               end
            endcase
         end
         hcbd_pkg::ST_NO_SIZE_LF: begin
            send_text("3");
            send_byte(hcbd_pkg::CH_CR);
            send_byte(random_except(hcbd_pkg::CH_LF));
         end
         hcbd_pkg::ST_OVERFLOW: begin
            send_text("8");
            repeat (8) send_byte(hex_char(4'($urandom_range(15))));
         end
         hcbd_pkg::ST_NO_DATA_CR: begin
            if ($urandom_range(1)) begin
               send_text("1");
               send_crlf();
               send_data(1);
            end else begin
               send_text("0");
               send_crlf();
            end
            send_byte(random_except(hcbd_pkg::CH_CR));
         end
         default: begin
            send_text("2");
            send_crlf();
            send_data(2);
            send_byte(hcbd_pkg::CH_CR);
            send_byte(random_except(hcbd_pkg::CH_LF));
         end
      endcase
      send_data(12);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_csr_access();
      test_directed_framing();
      test_random_chunks(0, 0, 1'b1, 300);
      test_random_chunks(85, 0, 1'b0, 250);
      test_random_chunks(0, 85, 1'b1, 250);
      test_random_chunks(30, 30, 1'b0, 250);
      test_backpressure();
      test_drain_pause();
      test_termination();
      wait_results_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/hcbd_pkg.sv
hw/rtl/hcbd_csr.sv
hw/rtl/hcbd_fsm.sv
hw/rtl/http_chunked_body_decoder_top.sv
hw/rtl/hcbd_checker.sv
test/http_chunked_body_decoder_top_test.sv
